### hw/rtl/rpr_pkg.sv
`default_nettype none

package rpr_pkg;

   localparam int REQ_PAGE_W    = 16;
   localparam int FRAME_INDEX_W = 3;
   localparam int FAULT_W       = 16;
   localparam int LFSR_W        = 16;
   localparam int FIU_W         = 4;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 16;

   localparam logic [FIU_W-1:0]   FIU_RESET  = 4'd8;
   localparam logic [LFSR_W-1:0]  SEED_RESET = 16'd1;
   localparam logic [FAULT_W-1:0] FAULT_MAX  = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAMES_IN_USE = 1'b0,
      CSR_RANDOM_SEED   = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

### hw/rtl/rpr_if.sv
`default_nettype none

interface rpr_req_if
   import rpr_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [REQ_PAGE_W-1:0] requested_page;

   modport source (output valid, output requested_page, input ready);
   modport sink   (input valid, input requested_page, output ready);
endinterface

interface rpr_rsp_if
   import rpr_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     hit;
   logic [FRAME_INDEX_W-1:0] frame_index;
   logic [FAULT_W-1:0]       fault_total;

   modport source (output valid, output hit, output frame_index, output fault_total,
                   input ready);
   modport sink   (input valid, input hit, input frame_index, input fault_total,
                   output ready);
endinterface

`default_nettype wire

### hw/rtl/random_page_replacement.sv
// Response cases: hit in frame k; a miss that fills an empty frame; a miss with all
// active frames full, which evicts a victim. The scan reads one frame per cycle from the
// page memory, then a 16-step serial remainder picks the victim.
// One request at a time; the next is taken once the previous response is registered.
// Synchronous active-high reset clears valid marks, fault count; LFSR to 1, config to 8.
`default_nettype none

module random_page_replacement
   import rpr_pkg::*;
#(
   parameter int FRAME_COUNT = 8,
   parameter int PAGE_BITS   = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   rpr_req_if.sink                     req_if,
   rpr_rsp_if.source                   rsp_if
);

   localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int CAP   = (FRAME_COUNT > 15) ? 15 : FRAME_COUNT;
   localparam int CMP_W = (IDX_W > FIU_W) ? IDX_W : FIU_W;
   localparam logic [FIU_W-1:0] N_CAP = FIU_W'(CAP);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAW, ST_FINISH} state_type;

   function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
      logic fb;
      fb = v[0] ^ v[2] ^ v[3] ^ v[5];
      return {fb, v[LFSR_W-1:1]};
   endfunction

   state_type                state_ff;
   logic [FIU_W-1:0]         fiu_ff;
   logic [LFSR_W-1:0]        lfsr_ff;
   logic [FAULT_W-1:0]       fault_ff;
   logic [FRAME_COUNT-1:0]   valid_ff;
   logic [PAGE_BITS-1:0]     page_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic [FIU_W-1:0]         n_ff;
   logic                     empty_found_ff;
   logic [IDX_W-1:0]         empty_idx_ff;
   logic [IDX_W-1:0]         slot_ff;
   logic                     hit_ff;
   logic                     draw_start_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_hit_ff;
   logic [FRAME_INDEX_W-1:0] rsp_frame_ff;
   logic [FAULT_W-1:0]       rsp_fault_ff;

   logic [FIU_W-1:0]     n_act;
   logic                 accept;
   logic                 out_free;
   logic                 match;
   logic                 last;
   logic [FAULT_W-1:0]   fault_in;
   logic [PAGE_BITS-1:0] mem_rdata;
   logic [IDX_W-1:0]     mem_raddr;
   logic                 mem_we;
   logic                 mod_done;
   logic [FIU_W-1:0]     mod_rem;
   logic [LFSR_W-1:0]    seed_in;
   logic                 draw_start_in;
   logic                 rsp_valid_in;

   always_comb begin
      if (fiu_ff == '0) begin
         n_act = FIU_W'(1);
      end else if (fiu_ff > N_CAP) begin
         n_act = N_CAP;
      end else begin
         n_act = fiu_ff;
      end
   end

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign match        = valid_ff[idx_ff] && (mem_rdata == page_ff);
   assign last         = CMP_W'(idx_ff) == CMP_W'(n_ff - FIU_W'(1));
   assign fault_in     = (fault_ff == FAULT_MAX) ? fault_ff : fault_ff + 1'b1;
   assign mem_raddr    = (state_ff == ST_IDLE) ? '0 : idx_ff + 1'b1;
   assign mem_we       = (state_ff == ST_FINISH) && out_free && !hit_ff;
   assign seed_in      = (csr_wdata[LFSR_W-1:0] == '0) ? SEED_RESET
                                                       : csr_wdata[LFSR_W-1:0];
   assign draw_start_in = (state_ff == ST_SCAN) && !match && last && !empty_found_ff &&
                          valid_ff[idx_ff];
   assign rsp_valid_in  = ((state_ff == ST_FINISH) && out_free) ||
                          (rsp_valid_ff && !rsp_if.ready);

   rpr_frame_mem #(
      .DEPTH (FRAME_COUNT),
      .WIDTH (PAGE_BITS)
   ) u_frame_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (slot_ff),
      .wr_data (page_ff),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   rpr_victim_mod u_victim_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (draw_start_ff),
      .dividend  (lfsr_ff),
      .divisor   (n_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fiu_ff         <= FIU_RESET;
         lfsr_ff        <= SEED_RESET;
         fault_ff       <= '0;
         valid_ff       <= '0;
         draw_start_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         empty_found_ff <= 1'b0;
      end else begin
         draw_start_ff <= draw_start_in;
         rsp_valid_ff  <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  page_ff        <= PAGE_BITS'(req_if.requested_page);
                  idx_ff         <= '0;
                  n_ff           <= n_act;
                  empty_found_ff <= 1'b0;
                  state_ff       <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (match) begin
                  slot_ff  <= idx_ff;
                  hit_ff   <= 1'b1;
                  state_ff <= ST_FINISH;
               end else begin
                  if (!valid_ff[idx_ff] && !empty_found_ff) begin
                     empty_found_ff <= 1'b1;
                     empty_idx_ff   <= idx_ff;
                  end
                  if (last) begin
                     hit_ff <= 1'b0;
                     if (empty_found_ff) begin
                        slot_ff  <= empty_idx_ff;
                        state_ff <= ST_FINISH;
                     end else if (!valid_ff[idx_ff]) begin
                        slot_ff  <= idx_ff;
                        state_ff <= ST_FINISH;
                     end else begin
                        state_ff <= ST_DRAW;
                     end
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            ST_DRAW: begin
               if (mod_done) begin
                  slot_ff  <= IDX_W'(mod_rem);
                  lfsr_ff  <= lfsr_next(lfsr_ff);
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_hit_ff   <= hit_ff;
                  rsp_frame_ff <= FRAME_INDEX_W'(slot_ff);
                  rsp_fault_ff <= hit_ff ? fault_ff : fault_in;
                  if (!hit_ff) begin
                     fault_ff          <= fault_in;
                     valid_ff[slot_ff] <= 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
         endcase
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_FRAMES_IN_USE: fiu_ff  <= csr_wdata[FIU_W-1:0];
               CSR_RANDOM_SEED:   lfsr_ff <= seed_in;
            endcase
         end
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.hit         = rsp_hit_ff;
   assign rsp_if.frame_index = rsp_frame_ff;
   assign rsp_if.fault_total = rsp_fault_ff;

endmodule

`default_nettype wire

### hw/rtl/rpr_frame_mem.sv
`default_nettype none

module rpr_frame_mem #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/rpr_victim_mod.sv
`default_nettype none

module rpr_victim_mod
   import rpr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [LFSR_W-1:0] dividend,
   input  wire logic [FIU_W-1:0]  divisor,
   output logic                   done,
   output logic      [FIU_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(LFSR_W);

   logic [LFSR_W-1:0] shift_ff;
   logic [FIU_W-1:0]  rem_ff;
   logic [FIU_W-1:0]  div_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [FIU_W:0]    trial;
   logic [FIU_W:0]    diff;
   logic [FIU_W-1:0]  rem_in;

   // restoring remainder, one dividend bit per cycle, MSB first
   always_comb begin
      trial  = {rem_ff, shift_ff[LFSR_W-1]};
      diff   = trial - {1'b0, div_ff};
      rem_in = (trial >= {1'b0, div_ff}) ? diff[FIU_W-1:0] : trial[FIU_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == '0);
         if (start) begin
            busy_ff  <= 1'b1;
            shift_ff <= dividend;
            div_ff   <= divisor;
            rem_ff   <= '0;
            cnt_ff   <= '1;
         end else if (busy_ff) begin
            rem_ff   <= rem_in;
            shift_ff <= {shift_ff[LFSR_W-2:0], 1'b0};
            cnt_ff   <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### verif/tb_top.sv
module tb_top;
   import rpr_pkg::*;

   localparam int FRAMES         = 8;
   localparam int ITEM_TARGET    = 1350;
   localparam int QUIET_TAIL     = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIRECTED_LEN   = 27;

   localparam logic ROW_REQ = 1'b0;
   localparam logic ROW_CSR = 1'b1;

   typedef struct packed {
      logic                     hit;
      logic [FRAME_INDEX_W-1:0] frame_index;
      logic [FAULT_W-1:0]       fault_total;
   } outcome_type;

   typedef struct packed {
      logic                  kind;
      csr_index_type         reg_sel;
      logic [CSR_DATA_W-1:0] value;
      logic                  typed;
      outcome_type           want;
   } step_type;

   localparam outcome_type NO_OUTCOME = '{1'b0, 3'd0, 16'd0};

   // Typed rows follow from the reset state (8 frames, LFSR = 1); the rest go to the predictor.
   localparam step_type DIRECTED_STEPS [DIRECTED_LEN] = '{
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'h0000, 1'b1, '{1'b0, 3'd0, 16'd1}},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'hFFFF, 1'b1, '{1'b0, 3'd1, 16'd2}},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'h0000, 1'b1, '{1'b1, 3'd0, 16'd2}},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'hFFFF, 1'b1, '{1'b1, 3'd1, 16'd2}},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'h5555, 1'b1, '{1'b0, 3'd2, 16'd3}},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'hAAAA, 1'b1, '{1'b0, 3'd3, 16'd4}},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'h0001, 1'b1, '{1'b0, 3'd4, 16'd5}},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'h8000, 1'b1, '{1'b0, 3'd5, 16'd6}},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'h7FFF, 1'b1, '{1'b0, 3'd6, 16'd7}},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'h1234, 1'b1, '{1'b0, 3'd7, 16'd8}},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'h4321, 1'b1, '{1'b0, 3'd1, 16'd9}},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'hFFFF, 1'b0, NO_OUTCOME},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'h4321, 1'b1, '{1'b1, 3'd1, 16'd10}},
      '{ROW_CSR, CSR_FRAMES_IN_USE, 16'd0,    1'b0, NO_OUTCOME},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'hFFFF, 1'b1, '{1'b1, 3'd0, 16'd10}},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'h5555, 1'b0, NO_OUTCOME},
      '{ROW_CSR, CSR_FRAMES_IN_USE, 16'd15,   1'b0, NO_OUTCOME},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'h5555, 1'b1, '{1'b1, 3'd0, 16'd11}},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'hAAAA, 1'b1, '{1'b1, 3'd3, 16'd11}},
      '{ROW_CSR, CSR_RANDOM_SEED,   16'h0000, 1'b0, NO_OUTCOME},
      '{ROW_CSR, CSR_FRAMES_IN_USE, 16'd3,    1'b0, NO_OUTCOME},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'h7FFF, 1'b0, NO_OUTCOME},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'h8000, 1'b0, NO_OUTCOME},
      '{ROW_CSR, CSR_RANDOM_SEED,   16'hFFFF, 1'b0, NO_OUTCOME},
      '{ROW_CSR, CSR_FRAMES_IN_USE, 16'd8,    1'b0, NO_OUTCOME},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'h0F0F, 1'b0, NO_OUTCOME},
      '{ROW_REQ, CSR_FRAMES_IN_USE, 16'h0F0F, 1'b1, '{1'b1, 3'd7, 16'd14}}
   };

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   rpr_req_if req_ch ();
   rpr_rsp_if rsp_ch ();

   random_page_replacement #(
      .FRAME_COUNT (FRAMES),
      .PAGE_BITS   (REQ_PAGE_W)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch)
   );

   // replacement state mirrored for prediction
   logic [REQ_PAGE_W-1:0] held_page [FRAMES];
   bit                    held_valid [FRAMES];
   logic [FIU_W-1:0]      frames_cfg   = FIU_RESET;
   logic [LFSR_W-1:0]     victim_state = SEED_RESET;
   logic [FAULT_W-1:0]    fault_tally  = '0;

   outcome_type expected_rsp [$];
   int          mismatches      = 0;
   int          rsp_seen        = 0;
   int          quiet_cycles    = 0;
   bit          sender_gaps     = 1'b1;
   bit          receiver_stalls = 1'b1;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned active_span(input logic [FIU_W-1:0] setting);
      if (setting == 0) return 1;
      if (setting > FRAMES) return FRAMES;
      return 32'(setting);
   endfunction

   function automatic outcome_type resolve_page(input logic [REQ_PAGE_W-1:0] page);
      int unsigned span;
      int unsigned idx;
      int unsigned slot;
      logic        found;
      logic        has_room;
      logic        feedback;
      outcome_type result;
      span     = active_span(frames_cfg);
      found    = 1'b0;
      has_room = 1'b0;
      slot     = 0;
      for (idx = 0; idx < span; idx++) begin
         if (!found && held_valid[idx] && held_page[idx] == page) begin
            slot  = idx;
            found = 1'b1;
         end
      end
      if (!found) begin
         for (idx = 0; idx < span; idx++) begin
            if (!has_room && !held_valid[idx]) begin
               slot     = idx;
               has_room = 1'b1;
            end
         end
         if (!has_room) begin
            slot         = victim_state % span;
            feedback     = victim_state[0] ^ victim_state[2] ^ victim_state[3] ^ victim_state[5];
            victim_state = {feedback, victim_state[LFSR_W-1:1]};
         end
         held_page[slot]  = page;
         held_valid[slot] = 1'b1;
         if (fault_tally != FAULT_MAX) fault_tally++;
      end
      result.hit         = found;
      result.frame_index = slot[FRAME_INDEX_W-1:0];
      result.fault_total = fault_tally;
      return result;
   endfunction

   task automatic send_page(input logic [REQ_PAGE_W-1:0] page, input logic typed,
                            input outcome_type typed_want);
      outcome_type predicted;
      req_ch.valid          <= 1'b1;
      req_ch.requested_page <= page;
      do @(posedge clock); while (!req_ch.ready);
      predicted = resolve_page(page);
      expected_rsp.push_back(typed ? typed_want : predicted);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // hold off new requests until every outstanding response is back
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type sel, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (sel == CSR_FRAMES_IN_USE) frames_cfg = value[FIU_W-1:0];
      else victim_state = (value == 0) ? LFSR_W'(1) : value;
      @(posedge clock);
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (receiver_stalls && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_responses
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.hit, rsp_ch.frame_index, rsp_ch.fault_total};
         if (expected_rsp.size() == 0) begin
            if (mismatches < 10)
               $display("response %0d: unexpected, hit=%0b frame=%0d faults=%0d",
                        rsp_seen, got.hit, got.frame_index, got.fault_total);
            mismatches++;
         end else begin
            want = expected_rsp.pop_front();
            if (got.hit !== want.hit || got.frame_index !== want.frame_index ||
                got.fault_total !== want.fault_total) begin
               if (mismatches < 10)
                  $display("response %0d: expected %0b/%0d/%0d, got %0b/%0d/%0d",
                           rsp_seen, want.hit, want.frame_index, want.fault_total,
                           got.hit, got.frame_index, got.fault_total);
               mismatches++;
            end
         end
         rsp_seen++;
      end
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      int                    row;
      int                    sent;
      int unsigned           span;
      int unsigned           pool_len;
      int unsigned           burst;
      int unsigned           idx;
      logic [FIU_W-1:0]      frames;
      logic [CSR_DATA_W-1:0] seed;
      logic [REQ_PAGE_W-1:0] page;
      logic [REQ_PAGE_W-1:0] pool [2*FRAMES+2];

      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_index             <= CSR_FRAMES_IN_USE;
      csr_wdata             <= '0;
      req_ch.valid          <= 1'b0;
      req_ch.requested_page <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sent = 0;
      for (row = 0; row < DIRECTED_LEN; row++) begin
         if (DIRECTED_STEPS[row].kind == ROW_CSR) begin
            settle();
            write_reg(DIRECTED_STEPS[row].reg_sel, DIRECTED_STEPS[row].value);
         end else begin
            send_page(DIRECTED_STEPS[row].value, DIRECTED_STEPS[row].typed,
                      DIRECTED_STEPS[row].want);
            sent++;
         end
      end

      // Each phase: new frame count, maybe a new seed, then a working set of pages
      // reused heavily so that hits, fills and evictions all occur.
      while (sent < ITEM_TARGET) begin
         settle();
         sender_gaps     = (sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         receiver_stalls = (sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 3))
            0: frames = 4'd1;
            1: frames = 4'd8;
            default: frames = FIU_W'($urandom_range(0, 15));
         endcase
         write_reg(CSR_FRAMES_IN_USE, CSR_DATA_W'(frames));
         if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 5))
               0: seed = 16'h0000;
               1: seed = 16'hFFFF;
               default: seed = CSR_DATA_W'($urandom_range(1, 65535));
            endcase
            write_reg(CSR_RANDOM_SEED, seed);
         end
         span     = active_span(frames);
         pool_len = span + $urandom_range(0, span + 2);
         for (idx = 0; idx < pool_len; idx++) pool[idx] = REQ_PAGE_W'($urandom_range(0, 65535));
         burst = $urandom_range(30, 90);
         repeat (burst) begin
            if ($urandom_range(0, 5) == 0) page = REQ_PAGE_W'($urandom_range(0, 65535));
            else page = pool[$urandom_range(0, pool_len - 1)];
            send_page(page, 1'b0, NO_OUTCOME);
            sent++;
         end
      end

      settle();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

### random_page_replacement.f
hw/rtl/rpr_pkg.sv
hw/rtl/rpr_if.sv
hw/rtl/rpr_frame_mem.sv
hw/rtl/rpr_victim_mod.sv
hw/rtl/random_page_replacement.sv
verif/tb_top.sv
